FILE: rtl/core/rhht_pkg.sv
// package for the robin hood hash table
// types, codes and default constants; no dependencies
package rhht_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int HASH_BITS      = 48;
    localparam int COUNT_BITS     = 11;
    localparam logic [COUNT_BITS-1:0] MAX_FILL_RESET = 11'd768;

    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] hash_value;
        logic [31:0] key;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [10:0] entry_count;
    } t_out_word;

endpackage

FILE: rtl/core/robin_hood_hash_table_top.sv
// robin hood hash table, open addressing with backward-shift delete
// each probed slot is read, then checked; clear empties the table one slot per cycle
// one word at a time, ready only in idle with no word waiting; a set of a new key probes twice unless full
// every probe reads the slot memory through its one port (registered read), under the sequencer
// reset: synchronous active low, then a clearing pass over all SLOTS slots, not ready during it
// depends on rhht_pkg
module robin_hood_hash_table_top #(
    parameter int SLOTS      = rhht_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = rhht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = rhht_pkg::VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rhht_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhht_pkg::t_out_word  o_data,
    input  logic                 i_cfg_we,
    input  logic [10:0]          i_cfg_data
);
    import rhht_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int DW = IW + 1;              // distance never exceeds SLOTS
    localparam int CW = IW + 1;

    typedef struct packed {
        logic [HASH_BITS-1:0]  hash;
        logic [DW-1:0]         psl;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
    } t_slot;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FRD, S_FCHK, S_IRD, S_ICHK, S_SRD, S_SCHK, S_TAIL, S_OUT
    } t_state;

    t_state r_state;
    t_slot  r_mem [SLOTS];
    t_slot  r_rd;
    t_slot  r_cand;
    logic [IW-1:0] r_idx, r_prev;
    logic [CW-1:0] r_n;
    logic [1:0]  r_cmd;
    logic [HASH_BITS-1:0] r_hash;
    logic [KEY_BITS-1:0]  r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [10:0] r_count, r_max_fill;
    t_out_word r_out;
    logic r_ovalid;

    // memory port, one write and one registered read a cycle
    logic          we;
    logic [IW-1:0] waddr;
    t_slot         wdata;
    logic [IW-1:0] raddr;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[raddr];
    end

    function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
        nxt = (32'(i) + 1 >= SLOTS) ? '0 : IW'(32'(i) + 1);
    endfunction

    logic [IW-1:0] home;
    assign home = IW'(i_data.hash_value % SLOTS);

    logic hit;
    assign hit = (r_rd.psl != '0) && r_rd.hash == r_hash && r_rd.key == r_key;
    logic done_n;
    assign done_n = (32'(r_n) + 1 >= SLOTS);

    always_comb begin
        we = 1'b0; waddr = r_idx; wdata = '0; raddr = r_idx;
        case (r_state)
            S_CLR: begin we = 1'b1; waddr = r_idx; end
            S_FCHK: begin
                if (hit && r_cmd == CMD_SET) begin
                    we = 1'b1; wdata = r_rd; wdata.val = r_val;
                end
            end
            S_ICHK: begin
                if (r_rd.psl == '0 || r_rd.psl < r_cand.psl) begin
                    we = 1'b1; wdata = r_cand;
                end
            end
            S_SCHK: begin
                we = 1'b1; waddr = r_prev;
                if (r_rd.psl > DW'(1)) begin
                    wdata = r_rd; wdata.psl = r_rd.psl - DW'(1);
                end
            end
            // last slot of a full-length shift is emptied
            S_TAIL: begin we = 1'b1; waddr = r_prev; end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_idx <= '0; r_count <= '0;
            r_max_fill <= MAX_FILL_RESET; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_fill <= i_cfg_data;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_idx <= nxt(r_idx);
                    if (32'(r_idx) == SLOTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_data.cmd;
                        r_hash <= i_data.hash_value;
                        r_key <= KEY_BITS'(i_data.key);
                        r_val <= VALUE_BITS'(i_data.value);
                        r_n <= '0;
                        r_out.value_out <= '0;
                        if (i_data.cmd == CMD_CLEAR) begin
                            r_idx <= '0; r_count <= '0;
                            r_out.status <= ST_CLEARED; r_out.entry_count <= '0;
                            r_ovalid <= 1'b1; r_state <= S_CLR;
                        end else begin
                            r_idx <= home; r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (hit) begin
                        if (r_cmd == CMD_SET) begin
                            r_out.status <= ST_REPLACED; r_state <= S_OUT;
                        end else if (r_cmd == CMD_GET) begin
                            r_out.status <= ST_FOUND;
                            r_out.value_out <= 32'(r_rd.val); r_state <= S_OUT;
                        end else begin
                            r_out.value_out <= 32'(r_rd.val);
                            r_prev <= r_idx; r_idx <= nxt(r_idx);
                            r_n <= '0; r_state <= S_SRD;
                        end
                    end else if (r_rd.psl == '0 || done_n) begin
                        if (r_cmd == CMD_SET) begin
                            if (r_count >= r_max_fill || 32'(r_count) >= SLOTS) begin
                                r_out.status <= ST_FULL; r_state <= S_OUT;
                            end else begin
                                r_idx <= IW'(r_hash % SLOTS); r_n <= '0;
                                r_cand <= '{r_hash, DW'(1), r_key, r_val};
                                r_state <= S_IRD;
                            end
                        end else begin
                            r_out.status <= ST_NOT_FOUND; r_state <= S_OUT;
                        end
                    end else begin
                        r_idx <= nxt(r_idx); r_n <= r_n + CW'(1); r_state <= S_FRD;
                    end
                end
                S_IRD: r_state <= S_ICHK;
                S_ICHK: begin
                    if (r_rd.psl == '0 || done_n) begin
                        if (r_rd.psl == '0) r_count <= r_count + 11'd1;
                        r_out.status <= ST_INSERTED; r_state <= S_OUT;
                    end else begin
                        // candidate distance grows by one per step
                        if (r_rd.psl < r_cand.psl) begin
                            r_cand <= '{r_rd.hash, r_rd.psl + DW'(1), r_rd.key, r_rd.val};
                        end else begin
                            r_cand.psl <= r_cand.psl + DW'(1);
                        end
                        r_idx <= nxt(r_idx); r_n <= r_n + CW'(1); r_state <= S_IRD;
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (r_rd.psl <= DW'(1)) begin
                        if (r_count != '0) r_count <= r_count - 11'd1;
                        r_out.status <= ST_REMOVED; r_state <= S_OUT;
                    end else if (done_n) begin
                        r_prev <= r_idx; r_state <= S_TAIL;
                    end else begin
                        r_prev <= r_idx; r_idx <= nxt(r_idx);
                        r_n <= r_n + CW'(1); r_state <= S_SRD;
                    end
                end
                S_TAIL: begin
                    if (r_count != '0) r_count <= r_count - 11'd1;
                    r_out.status <= ST_REMOVED; r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out.entry_count <= r_count;
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/rhht_checker.sv
// port checker for the robin hood hash table
// depends on rhht_pkg and robin_hood_hash_table_top
module rhht_checker (
    input logic i_clk, input logic i_rst_n,
    input logic i_valid, input logic o_ready,
    input logic o_valid, input logic i_ready,
    input rhht_pkg::t_out_word o_data
);
    import rhht_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out word dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready with pending word");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready right after accept");
    a_vout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !(o_data.status == ST_FOUND || o_data.status == ST_REMOVED)
        |-> o_data.value_out == '0) else $error("stray value");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_CLEARED |-> o_data.entry_count == '0)
        else $error("clear count");
endmodule

bind robin_hood_hash_table_top rhht_checker u_chk (.*);
